### src/pien_pkg.sv
// ============================================================================
// pien_pkg
// Shared types, constants and helper functions for the pendulum stepper.
// ============================================================================
`default_nettype none

package pien_pkg;

    // Fixed-point format of all state and register values (signed Q8.24).
    localparam int FRAC_BITS     = 24;
    // CORDIC works in Q2.30; outputs are floored back to FRAC_BITS.
    localparam int CORDIC_STAGES = 30;
    localparam int CORDIC_SHIFT  = 30 - FRAC_BITS;
    // Angle magnitude in Q30 before reduction.
    localparam int RMAG_W        = 32 + CORDIC_SHIFT;
    // Quotient of the angle reduction stays below 2^REDUCE_STEPS.
    localparam int REDUCE_STEPS  = 5;
    // Numerator width of the fixed-point quotient.
    localparam int NUM_W         = 32 + FRAC_BITS;
    localparam int DIV_STEPS     = 32;

    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Micro-operation codes issued by the controller.
    localparam int OP_W = 6;
    localparam logic [OP_W-1:0] OP_IDLE   = 6'd0;
    localparam logic [OP_W-1:0] OP_M_HA   = 6'd1;
    localparam logic [OP_W-1:0] OP_W_HA   = 6'd2;
    localparam logic [OP_W-1:0] OP_M_H2A  = 6'd3;
    localparam logic [OP_W-1:0] OP_W_H2A  = 6'd4;
    localparam logic [OP_W-1:0] OP_RED_I  = 6'd5;
    localparam logic [OP_W-1:0] OP_RED_S  = 6'd6;
    localparam logic [OP_W-1:0] OP_RED_F  = 6'd7;
    localparam logic [OP_W-1:0] OP_FOLD   = 6'd8;
    localparam logic [OP_W-1:0] OP_CORDIC = 6'd9;
    localparam logic [OP_W-1:0] OP_CS     = 6'd10;
    localparam logic [OP_W-1:0] OP_M_F0   = 6'd11;
    localparam logic [OP_W-1:0] OP_W_F0   = 6'd12;
    localparam logic [OP_W-1:0] OP_M_F1   = 6'd13;
    localparam logic [OP_W-1:0] OP_W_F1   = 6'd14;
    localparam logic [OP_W-1:0] OP_M_HAC  = 6'd15;
    localparam logic [OP_W-1:0] OP_W_HAC  = 6'd16;
    localparam logic [OP_W-1:0] OP_M_DET  = 6'd17;
    localparam logic [OP_W-1:0] OP_W_DET  = 6'd18;
    localparam logic [OP_W-1:0] OP_M_N0   = 6'd19;
    localparam logic [OP_W-1:0] OP_W_N0   = 6'd20;
    localparam logic [OP_W-1:0] OP_M_N1   = 6'd21;
    localparam logic [OP_W-1:0] OP_W_N1   = 6'd22;
    localparam logic [OP_W-1:0] OP_DIV_I  = 6'd23;
    localparam logic [OP_W-1:0] OP_DIV_S  = 6'd24;
    localparam logic [OP_W-1:0] OP_DIV_F  = 6'd25;
    localparam logic [OP_W-1:0] OP_UPD    = 6'd26;
    localparam logic [OP_W-1:0] OP_MAG    = 6'd27;
    localparam logic [OP_W-1:0] OP_M_E0   = 6'd28;
    localparam logic [OP_W-1:0] OP_W_E0   = 6'd29;
    localparam logic [OP_W-1:0] OP_M_E1   = 6'd30;
    localparam logic [OP_W-1:0] OP_W_E1   = 6'd31;
    localparam logic [OP_W-1:0] OP_CHK    = 6'd32;
    localparam logic [OP_W-1:0] OP_FIN    = 6'd33;

    // Configuration register indexes.
    localparam logic [2:0] REG_STEP_SIZE  = 3'd0;
    localparam logic [2:0] REG_ALPHA_SQ   = 3'd1;
    localparam logic [2:0] REG_THETA_INIT = 3'd2;
    localparam logic [2:0] REG_TOL_SQ     = 3'd3;
    localparam logic [2:0] REG_MAX_ITERS  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [4:0]      idx;
        logic            load;
        logic            restart;
    } pien_cmd_t;

    typedef struct packed {
        logic stop;
        logic out_busy;
    } pien_sts_t;

    typedef struct packed {
        logic [30:0]        step_size;
        logic [30:0]        alpha_sq;
        logic signed [31:0] theta_init;
        logic [30:0]        tol_sq;
        logic [3:0]         max_iters;
    } pien_cfg_t;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        begin
            case (i)
                5'd0:    v = 30'h3243F6A8;
                5'd1:    v = 30'h1DAC6705;
                5'd2:    v = 30'h0FADBAFC;
                5'd3:    v = 30'h07F56EA6;
                5'd4:    v = 30'h03FEAB76;
                5'd5:    v = 30'h01FFD55B;
                5'd6:    v = 30'h00FFFAAA;
                5'd7:    v = 30'h007FFF55;
                5'd8:    v = 30'h003FFFEA;
                5'd9:    v = 30'h001FFFFD;
                5'd10:   v = 30'h000FFFFF;
                5'd11:   v = 30'h0007FFFF;
                5'd12:   v = 30'h0003FFFF;
                5'd13:   v = 30'h0001FFFF;
                5'd14:   v = 30'h0000FFFF;
                5'd15:   v = 30'h00007FFF;
                5'd16:   v = 30'h00003FFF;
                5'd17:   v = 30'h00001FFF;
                5'd18:   v = 30'h00000FFF;
                5'd19:   v = 30'h000007FF;
                5'd20:   v = 30'h000003FF;
                5'd21:   v = 30'h000001FF;
                5'd22:   v = 30'h000000FF;
                5'd23:   v = 30'h0000007F;
                5'd24:   v = 30'h0000003F;
                5'd25:   v = 30'h0000001F;
                5'd26:   v = 30'h0000000F;
                5'd27:   v = 30'h00000008;
                5'd28:   v = 30'h00000004;
                5'd29:   v = 30'h00000002;
                default: v = 30'h0;
            endcase
            atan_q30 = $signed({5'b0, v});
        end
    endfunction

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647) begin
                sat32 = 32'sh7FFFFFFF;
            end
            else if (v < -64'sd2147483648) begin
                sat32 = 32'sh80000000;
            end
            else begin
                sat32 = v[31:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

### src/pien_req_if.sv
// ============================================================================
// pien_req_if
// Request channel of the pendulum stepper: one time step per request.
// ============================================================================
`default_nettype none

interface pien_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

### src/pien_rsp_if.sv
// ============================================================================
// pien_rsp_if
// Result channel of the pendulum stepper: new state and iteration status.
// ============================================================================
`default_nettype none

interface pien_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] theta_out;
    logic signed [31:0] omega_out;
    logic [3:0]         newton_iters;
    logic               converged;
    logic [15:0]        step_index;

    modport source (output valid, output theta_out, output omega_out,
                    output newton_iters, output converged, output step_index,
                    input ready);
    modport sink   (input valid, input theta_out, input omega_out,
                    input newton_iters, input converged, input step_index,
                    output ready);
endinterface

`default_nettype wire

### src/pien_ctrl.sv
// ============================================================================
// pien_ctrl
// Sequencer that walks the datapath through one Newton-solved time step.
// ============================================================================
`default_nettype none

module pien_ctrl
    import pien_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire pien_sts_t sts,
    output pien_cmd_t      cmd,
    input  wire logic      req_restart
);

    logic [OP_W-1:0] state_reg, state_next;
    logic [4:0]      cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= OP_IDLE;
            cnt_reg   <= '0;
        end
        else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            OP_IDLE: begin
                if (req_valid) begin
                    state_next = OP_M_HA;
                end
            end
            OP_RED_I: begin
                state_next = OP_RED_S;
                cnt_next   = 5'(REDUCE_STEPS - 1);
            end
            OP_RED_S: begin
                if (cnt_reg == 5'd0) begin
                    state_next = OP_RED_F;
                end
                else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            OP_FOLD: begin
                state_next = OP_CORDIC;
                cnt_next   = '0;
            end
            OP_CORDIC: begin
                if (cnt_reg == 5'(CORDIC_STAGES - 1)) begin
                    state_next = OP_CS;
                end
                else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            OP_DIV_I: begin
                state_next = OP_DIV_S;
                cnt_next   = '0;
            end
            OP_DIV_S: begin
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = OP_DIV_F;
                end
                else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            OP_CHK: begin
                state_next = sts.stop ? OP_FIN : OP_RED_I;
            end
            OP_FIN: begin
                if (!sts.out_busy) begin
                    state_next = OP_IDLE;
                end
            end
            default: begin
                // Straight-line micro-operations simply advance.
                if (state_reg < OP_FIN) begin
                    state_next = state_reg + 6'd1;
                end
                else begin
                    state_next = OP_IDLE;
                end
            end
        endcase
    end

    assign req_ready   = (state_reg == OP_IDLE);
    assign cmd.op      = state_reg;
    assign cmd.idx     = cnt_reg;
    assign cmd.load    = (state_reg == OP_IDLE) && req_valid;
    assign cmd.restart = req_restart;

endmodule

`default_nettype wire

### src/pien_dp.sv
// ============================================================================
// pien_dp
// Datapath: shared multiplier, CORDIC, dual divider and the step state.
// ============================================================================
`default_nettype none

module pien_dp
    import pien_pkg::*;
#(
    parameter int STEP_COUNT_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pien_cmd_t   cmd,
    input  wire pien_cfg_t   cfg,
    output pien_sts_t        sts,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic signed [31:0] theta_out,
    output logic signed [31:0] omega_out,
    output logic [3:0]       newton_iters,
    output logic             converged,
    output logic [15:0]      step_index
);

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    // Step state (reset) and output register.
    logic signed [31:0]         th_reg, om_reg;
    logic [STEP_COUNT_BITS-1:0] cnt_reg, cnt_inc;
    logic                       out_valid_reg;

    // Working registers.
    logic signed [31:0] x0_reg, x1_reg, nx0_reg, nx1_reg;
    logic signed [31:0] ha_reg, h2a_reg, s_reg, c_reg;
    logic signed [31:0] f0_reg, f1_reg, hac_reg, n0_reg, n1_reg, q0_reg, q1_reg;
    logic signed [32:0] det_reg;
    logic signed [63:0] prod_reg;
    logic [3:0]         k_reg;
    logic               conv_reg;
    logic [RMAG_W-1:0]  rmag_reg;
    logic               rneg_reg, flip_reg;
    logic signed [34:0] r_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic [NUM_W-1:0]   rem0_reg, rem1_reg;
    logic [63:0]        dsh_reg;
    logic [31:0]        qd0_reg, qd1_reg;
    logic               ovf0_reg, ovf1_reg, neg0_reg, neg1_reg;
    logic [30:0]        m0_reg, m1_reg;
    logic [62:0]        acc_reg;
    logic signed [31:0] tho_reg, omo_reg;
    logic [3:0]         ito_reg;
    logic               cvo_reg;
    logic [15:0]        sio_reg;

    // Combinational helpers.
    logic signed [31:0] mul_a, mul_b, fm;
    logic signed [63:0] prod_sh, det_sum, q0_v, q1_v, d0, d1, r_sgn;
    logic [31:0]        n0_abs, n1_abs, x0_abs;
    logic [32:0]        det_abs, d0_abs, d1_abs, qm0, qm1;
    logic [NUM_W-1:0]   num0, num1;
    logic [63:0]        err_sum;
    logic [63:0]        err;
    logic [39:0]        red_cmp;
    logic signed [34:0] r_wrap, atan_v;
    logic signed [33:0] xs, ys;
    logic [3:0]         limit;
    logic [STEP_COUNT_BITS+15:0] cnt_ext;

    always_comb
    begin
        case (cmd.op)
            OP_M_HA:
            begin
                mul_a = $signed({1'b0, cfg.step_size});
                mul_b = $signed({1'b0, cfg.alpha_sq});
            end
            OP_M_H2A:
            begin
                mul_a = $signed({1'b0, cfg.step_size});
                mul_b = ha_reg;
            end
            OP_M_F0:
            begin
                mul_a = $signed({1'b0, cfg.step_size});
                mul_b = x1_reg;
            end
            OP_M_F1:
            begin
                mul_a = ha_reg;
                mul_b = s_reg;
            end
            OP_M_HAC:
            begin
                mul_a = ha_reg;
                mul_b = c_reg;
            end
            OP_M_DET:
            begin
                mul_a = h2a_reg;
                mul_b = c_reg;
            end
            OP_M_N0:
            begin
                mul_a = $signed({1'b0, cfg.step_size});
                mul_b = f1_reg;
            end
            OP_M_N1:
            begin
                mul_a = hac_reg;
                mul_b = f0_reg;
            end
            OP_M_E0:
            begin
                mul_a = $signed({1'b0, m0_reg});
                mul_b = $signed({1'b0, m0_reg});
            end
            OP_M_E1:
            begin
                mul_a = $signed({1'b0, m1_reg});
                mul_b = $signed({1'b0, m1_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product shifted with floor rounding and saturated.
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign fm      = sat32(prod_sh);
    assign det_sum = ONE + 64'(fm);

    // Angle reduction.
    assign x0_abs  = x0_reg[31] ? (~x0_reg + 32'd1) : x0_reg;
    assign red_cmp = 40'(TWO_PI_Q30) << cmd.idx;
    assign r_sgn   = rneg_reg ? -$signed(64'(rmag_reg)) : $signed(64'(rmag_reg));
    always_comb
    begin
        r_wrap = r_sgn[34:0];
        if (r_wrap > PI_Q30)
        begin
            r_wrap = r_wrap - TWO_PI_Q30;
        end
        else if (r_wrap < -PI_Q30)
        begin
            r_wrap = r_wrap + TWO_PI_Q30;
        end
    end

    // CORDIC stage operands.
    assign xs     = cx_reg >>> cmd.idx;
    assign ys     = cy_reg >>> cmd.idx;
    assign atan_v = atan_q30(cmd.idx);

    // Divider setup and result.
    assign n0_abs  = n0_reg[31] ? (~n0_reg + 32'd1) : n0_reg;
    assign n1_abs  = n1_reg[31] ? (~n1_reg + 32'd1) : n1_reg;
    assign det_abs = det_reg[32] ? (~det_reg + 33'd1) : det_reg;
    assign num0    = {n0_abs, {FRAC_BITS{1'b0}}};
    assign num1    = {n1_abs, {FRAC_BITS{1'b0}}};
    assign qm0     = ovf0_reg ? 33'h1_0000_0000 : {1'b0, qd0_reg};
    assign qm1     = ovf1_reg ? 33'h1_0000_0000 : {1'b0, qd1_reg};
    assign q0_v    = neg0_reg ? -$signed(64'(qm0)) : $signed(64'(qm0));
    assign q1_v    = neg1_reg ? -$signed(64'(qm1)) : $signed(64'(qm1));

    // Newton step magnitudes.
    assign d0     = 64'(nx0_reg) - 64'(x0_reg);
    assign d1     = 64'(nx1_reg) - 64'(x1_reg);
    assign d0_abs = d0[63] ? 33'(-d0) : d0[32:0];
    assign d1_abs = d1[63] ? 33'(-d1) : d1[32:0];

    assign err_sum = 64'(acc_reg) + 64'(prod_reg[62:0]);
    assign err     = err_sum >> FRAC_BITS;

    assign limit    = (cfg.max_iters == 4'd0) ? 4'd1 : cfg.max_iters;
    assign sts.stop = conv_reg || (k_reg >= limit);
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign cnt_inc = (cnt_reg == {STEP_COUNT_BITS{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
    assign cnt_ext = {16'b0, cnt_inc};

    // State that reset defines.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_reg        <= 32'sd26353589;
            om_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && cmd.restart)
            begin
                th_reg  <= cfg.theta_init;
                om_reg  <= '0;
                cnt_reg <= '0;
            end
            if ((cmd.op == OP_FIN) && !sts.out_busy)
            begin
                th_reg        <= x0_reg;
                om_reg        <= x1_reg;
                cnt_reg       <= cnt_inc;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_IDLE:
            begin
                if (cmd.load)
                begin
                    x0_reg   <= cmd.restart ? cfg.theta_init : th_reg;
                    x1_reg   <= cmd.restart ? 32'sd0 : om_reg;
                    k_reg    <= '0;
                    conv_reg <= 1'b0;
                end
            end
            OP_W_HA:  ha_reg  <= fm;
            OP_W_H2A: h2a_reg <= fm;
            OP_RED_I:
            begin
                rmag_reg <= {x0_abs, {CORDIC_SHIFT{1'b0}}};
                rneg_reg <= x0_reg[31];
            end
            OP_RED_S:
            begin
                if (40'(rmag_reg) >= red_cmp)
                begin
                    rmag_reg <= rmag_reg - red_cmp[RMAG_W-1:0];
                end
            end
            OP_RED_F: r_reg <= r_wrap;
            OP_FOLD:
            begin
                cx_reg <= CORDIC_GAIN;
                cy_reg <= '0;
                if (r_reg > HALF_PI_Q30)
                begin
                    r_reg    <= PI_Q30 - r_reg;
                    flip_reg <= 1'b1;
                end
                else if (r_reg < -HALF_PI_Q30)
                begin
                    r_reg    <= -PI_Q30 - r_reg;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    flip_reg <= 1'b0;
                end
            end
            OP_CORDIC:
            begin
                if (!r_reg[34])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    r_reg  <= r_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    r_reg  <= r_reg + atan_v;
                end
            end
            OP_CS:
            begin
                s_reg <= 32'(cy_reg >>> CORDIC_SHIFT);
                c_reg <= flip_reg ? -32'(cx_reg >>> CORDIC_SHIFT)
                                  : 32'(cx_reg >>> CORDIC_SHIFT);
            end
            OP_W_F0:  f0_reg  <= sat32(64'(x0_reg) - 64'(th_reg) - 64'(fm));
            OP_W_F1:  f1_reg  <= sat32(64'(x1_reg) - 64'(om_reg) + 64'(fm));
            OP_W_HAC: hac_reg <= fm;
            // A zero determinant is replaced by one LSB.
            OP_W_DET: det_reg <= (det_sum == 64'sd0) ? 33'sd1 : det_sum[32:0];
            OP_W_N0:  n0_reg  <= sat32(64'(f0_reg) + 64'(fm));
            OP_W_N1:  n1_reg  <= sat32(64'(f1_reg) - 64'(fm));
            OP_DIV_I:
            begin
                rem0_reg <= num0;
                rem1_reg <= num1;
                dsh_reg  <= {det_abs[31:0], 32'b0} >> 1;
                ovf0_reg <= 66'(num0) >= {1'b0, det_abs, 32'b0};
                ovf1_reg <= 66'(num1) >= {1'b0, det_abs, 32'b0};
                neg0_reg <= n0_reg[31] ^ det_reg[32];
                neg1_reg <= n1_reg[31] ^ det_reg[32];
                qd0_reg  <= '0;
                qd1_reg  <= '0;
            end
            OP_DIV_S:
            begin
                if (64'(rem0_reg) >= dsh_reg)
                begin
                    rem0_reg <= rem0_reg - dsh_reg[NUM_W-1:0];
                    qd0_reg  <= {qd0_reg[30:0], 1'b1};
                end
                else
                begin
                    qd0_reg <= {qd0_reg[30:0], 1'b0};
                end
                if (64'(rem1_reg) >= dsh_reg)
                begin
                    rem1_reg <= rem1_reg - dsh_reg[NUM_W-1:0];
                    qd1_reg  <= {qd1_reg[30:0], 1'b1};
                end
                else
                begin
                    qd1_reg <= {qd1_reg[30:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            OP_DIV_F:
            begin
                q0_reg <= sat32(q0_v);
                q1_reg <= sat32(q1_v);
            end
            OP_UPD:
            begin
                nx0_reg <= sat32(64'(x0_reg) - 64'(q0_reg));
                nx1_reg <= sat32(64'(x1_reg) - 64'(q1_reg));
            end
            OP_MAG:
            begin
                m0_reg <= (d0_abs > 33'h7FFFFFFF) ? 31'h7FFFFFFF : d0_abs[30:0];
                m1_reg <= (d1_abs > 33'h7FFFFFFF) ? 31'h7FFFFFFF : d1_abs[30:0];
            end
            OP_W_E0: acc_reg <= prod_reg[62:0];
            OP_W_E1:
            begin
                conv_reg <= err <= 64'(cfg.tol_sq);
                x0_reg   <= nx0_reg;
                x1_reg   <= nx1_reg;
                k_reg    <= k_reg + 4'd1;
            end
            OP_FIN:
            begin
                if (!sts.out_busy)
                begin
                    tho_reg <= x0_reg;
                    omo_reg <= x1_reg;
                    ito_reg <= k_reg;
                    cvo_reg <= conv_reg;
                    sio_reg <= cnt_ext[15:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign theta_out    = tho_reg;
    assign omega_out    = omo_reg;
    assign newton_iters = ito_reg;
    assign converged    = cvo_reg;
    assign step_index   = sio_reg;

endmodule

`default_nettype wire

### src/pendulum_implicit_euler_newton_top.sv
// ============================================================================
// pendulum_implicit_euler_newton_top
// Backward-Euler pendulum stepper solved by Newton iterations in Q8.24.
// ============================================================================
// Each request advances the pendulum state (angle, rate) by one implicit
// time step and returns one result with the new state, the number of Newton
// iterations used, a convergence flag and the saturating step index. A
// request with restart set first reloads the state to (theta_init, 0). One
// request is worked on at a time. A step runs k Newton iterations
// (1 to 15); each iteration uses an iterative CORDIC for sine and cosine,
// a shift-subtract divider that forms both quotients together, and the
// shared 32x32 multiplier that forms eight products in turn. The result
// sits in an output register, so the next request is accepted while the
// previous result still waits to be taken. Configuration registers must be
// written over the APB port only while the block is idle; the block itself
// does not enforce this.
// ============================================================================
`default_nettype none

module pendulum_implicit_euler_newton_top
    import pien_pkg::*;
#(
    parameter int STEP_COUNT_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    pien_req_if.sink         step_req,
    pien_rsp_if.source       step_rsp
);

    pien_cfg_t cfg_reg;
    pien_cmd_t cmd;
    pien_sts_t sts;
    logic      cfg_wr;

    // Registers are written in the access phase of an APB write.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.step_size  <= 31'd4194304;
            cfg_reg.alpha_sq   <= 31'd67108864;
            cfg_reg.theta_init <= 32'sd26353589;
            cfg_reg.tol_sq     <= 31'd0;
            cfg_reg.max_iters  <= 4'd10;
        end
        else if (cfg_wr) begin
            case (paddr[4:2])
                REG_STEP_SIZE:  cfg_reg.step_size  <= pwdata[30:0];
                REG_ALPHA_SQ:   cfg_reg.alpha_sq   <= pwdata[30:0];
                REG_THETA_INIT: cfg_reg.theta_init <= pwdata;
                REG_TOL_SQ:     cfg_reg.tol_sq     <= pwdata[30:0];
                REG_MAX_ITERS:  cfg_reg.max_iters  <= pwdata[3:0];
                default: begin
                    // Writes to unmapped addresses are dropped.
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_STEP_SIZE:  prdata = {1'b0, cfg_reg.step_size};
            REG_ALPHA_SQ:   prdata = {1'b0, cfg_reg.alpha_sq};
            REG_THETA_INIT: prdata = cfg_reg.theta_init;
            REG_TOL_SQ:     prdata = {1'b0, cfg_reg.tol_sq};
            REG_MAX_ITERS:  prdata = {28'b0, cfg_reg.max_iters};
            default:        prdata = '0;
        endcase
    end

    // The controller sequences the micro-operations of one step.
    pien_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (step_req.valid),
        .req_ready   (step_req.ready),
        .sts         (sts),
        .cmd         (cmd),
        .req_restart (step_req.restart)
    );

    // The datapath holds the pendulum state and all arithmetic units.
    pien_dp #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg_reg),
        .sts          (sts),
        .out_ready    (step_rsp.ready),
        .out_valid    (step_rsp.valid),
        .theta_out    (step_rsp.theta_out),
        .omega_out    (step_rsp.omega_out),
        .newton_iters (step_rsp.newton_iters),
        .converged    (step_rsp.converged),
        .step_index   (step_rsp.step_index)
    );

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the backward-Euler Newton pendulum stepper.
// ============================================================================
// Step requests are queued by a sequencing block and sent by a clocked driver.
// The driver predicts each result when the request is accepted. It does this
// with a bit-exact copy of the fixed-point Newton solver, which keeps its own
// state and registers. A clocked monitor compares every result, field by field,
// with the oldest prediction. Registers are written over APB only while the
// stepper is drained. The phases sweep register extremes and random settings.
// ============================================================================
`default_nettype none

module tb;
    import pien_pkg::*;

    localparam longint Q_ONE    = 64'sd1 << 24;
    localparam longint PI_Q     = 64'sd3373259426;
    localparam longint HPI_Q    = 64'sd1686629713;
    localparam longint TPI_Q    = 64'sd6746518852;
    localparam longint GAIN_Q   = 64'sd652032874;
    localparam longint CNT_MAX  = 64'sd65535;

    // Arctangent of 2^-i in Q2.30, used by the angle rotation below.
    localparam longint ATAN_TAB [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    typedef struct {
        logic signed [31:0] theta;
        logic signed [31:0] omega;
        logic [3:0]         iters;
        logic               conv;
        logic [15:0]        index;
    } step_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pien_req_if step_req ();
    pien_rsp_if step_rsp ();

    pendulum_implicit_euler_newton_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .step_req (step_req.sink),
        .step_rsp (step_rsp.source)
    );

    // Shadow copy of the registers and of the solver state.
    longint h_reg;
    longint asq_reg;
    longint th0_reg;
    longint tol_reg;
    longint iters_reg;
    longint theta_st;
    longint omega_st;
    longint step_cnt;

    logic         pending_restart [$];
    step_result_t expected_steps [$];
    int           fail_count;
    bit           idle_on;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return clamp32((a * b) >>> 24);
    endfunction

    function automatic longint qquot(input longint num, input longint den);
        return clamp32((num * Q_ONE) / den);
    endfunction

    function automatic longint unsigned mag_sq(input longint d);
        longint unsigned m;
        m = (d < 0) ? longint'(-d) : longint'(d);
        if (m > 64'h7FFFFFFF)
        begin
            m = 64'h7FFFFFFF;
        end
        return m * m;
    endfunction

    // Sine and cosine in Q8.24: reduce to [-pi/2, pi/2], rotate in Q2.30.
    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint r;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        r = (ang * 64) % TPI_Q;
        x = GAIN_Q;
        y = 0;
        flip = 1'b0;
        if (r > PI_Q) r -= TPI_Q;
        if (r < -PI_Q) r += TPI_Q;
        if (r > HPI_Q)
        begin
            r = PI_Q - r;
            flip = 1'b1;
        end
        else if (r < -HPI_Q)
        begin
            r = -PI_Q - r;
            flip = 1'b1;
        end
        for (int i = 0; i < 30; i++)
        begin
            if (r >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                r -= ATAN_TAB[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                r += ATAN_TAB[i];
            end
            x = nx;
        end
        s = y >>> 6;
        c = x >>> 6;
        if (flip) c = -c;
    endtask

    // One implicit time step; appends the predicted result.
    task automatic solve_step(input logic restart);
        longint       ha, h2a, x0, x1, s, c, f0, f1, hac, det, n0, n1, nx0, nx1;
        longint       lim, k;
        longint unsigned err;
        bit           conv;
        step_result_t res;
        if (restart)
        begin
            theta_st = th0_reg;
            omega_st = 0;
            step_cnt = 0;
        end
        lim = (iters_reg != 0) ? iters_reg : 1;
        k = 0;
        conv = 1'b0;
        ha = clamp32((h_reg * asq_reg) >>> 24);
        h2a = qmul(h_reg, ha);
        x0 = theta_st;
        x1 = omega_st;
        while (k < lim)
        begin
            sin_cos(x0, s, c);
            f0 = clamp32(x0 - theta_st - qmul(h_reg, x1));
            f1 = clamp32(x1 - omega_st + qmul(ha, s));
            hac = qmul(ha, c);
            det = Q_ONE + qmul(h2a, c);
            // A vanishing determinant is forced to one LSB.
            if (det == 0) det = 1;
            n0 = clamp32(f0 + qmul(h_reg, f1));
            n1 = clamp32(f1 - qmul(hac, f0));
            nx0 = clamp32(x0 - qquot(n0, det));
            nx1 = clamp32(x1 - qquot(n1, det));
            err = (mag_sq(nx0 - x0) + mag_sq(nx1 - x1)) >> 24;
            x0 = nx0;
            x1 = nx1;
            k++;
            if (err <= longint'(tol_reg))
            begin
                conv = 1'b1;
                break;
            end
        end
        theta_st = x0;
        omega_st = x1;
        if (step_cnt < CNT_MAX) step_cnt++;
        res.theta = x0[31:0];
        res.omega = x1[31:0];
        res.iters = k[3:0];
        res.conv  = conv;
        res.index = step_cnt[15:0];
        expected_steps.push_back(res);
    endtask

    // Driver: one request per handshake, prediction made at acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_req.valid   <= 1'b0;
            step_req.restart <= 1'b0;
        end
        else if (!step_req.valid || step_req.ready)
        begin
            if (step_req.valid)
            begin
                solve_step(step_req.restart);
            end
            if (pending_restart.size() > 0 && !(idle_on && $urandom_range(99) < 31))
            begin
                step_req.valid   <= 1'b1;
                step_req.restart <= pending_restart.pop_front();
            end
            else
            begin
                step_req.valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and field-by-field comparison.
    always @(posedge clk or negedge rst_n)
    begin
        step_result_t want;
        if (!rst_n)
        begin
            step_rsp.ready <= 1'b0;
        end
        else
        begin
            step_rsp.ready <= !(idle_on && $urandom_range(99) < 31);
            if (step_rsp.valid && step_rsp.ready)
            begin
                if (expected_steps.size() == 0)
                begin
                    $display("%0t: unexpected result theta %h", $time, step_rsp.theta_out);
                    fail_count++;
                end
                else
                begin
                    want = expected_steps.pop_front();
                    if (step_rsp.theta_out !== want.theta)
                    begin
                        $display("%0t: theta_out expected %h actual %h",
                                 $time, want.theta, step_rsp.theta_out);
                        fail_count++;
                    end
                    if (step_rsp.omega_out !== want.omega)
                    begin
                        $display("%0t: omega_out expected %h actual %h",
                                 $time, want.omega, step_rsp.omega_out);
                        fail_count++;
                    end
                    if (step_rsp.newton_iters !== want.iters)
                    begin
                        $display("%0t: newton_iters expected %0d actual %0d",
                                 $time, want.iters, step_rsp.newton_iters);
                        fail_count++;
                    end
                    if (step_rsp.converged !== want.conv)
                    begin
                        $display("%0t: converged expected %0d actual %0d",
                                 $time, want.conv, step_rsp.converged);
                        fail_count++;
                    end
                    if (step_rsp.step_index !== want.index)
                    begin
                        $display("%0t: step_index expected %0d actual %0d",
                                 $time, want.index, step_rsp.step_index);
                        fail_count++;
                    end
                end
            end
        end
    end

    // APB write: setup cycle, then access cycle; the shadow copy follows.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STEP_SIZE:  h_reg = value[30:0];
            REG_ALPHA_SQ:   asq_reg = value[30:0];
            REG_THETA_INIT: th0_reg = longint'($signed(value));
            REG_TOL_SQ:     tol_reg = value[30:0];
            REG_MAX_ITERS:  iters_reg = value[3:0];
            default:        ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] h, input logic [31:0] asq,
                            input logic [31:0] th0, input logic [31:0] tol,
                            input logic [31:0] iters);
        reg_write(REG_STEP_SIZE, h);
        reg_write(REG_ALPHA_SQ, asq);
        reg_write(REG_THETA_INIT, th0);
        reg_write(REG_TOL_SQ, tol);
        reg_write(REG_MAX_ITERS, iters);
    endtask

    // Every step yields a result, so an empty prediction queue means idle.
    task automatic drain();
        wait (pending_restart.size() == 0 && !step_req.valid && expected_steps.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_steps(input int count, input int restart_pct);
        for (int i = 0; i < count; i++)
        begin
            pending_restart.push_back($urandom_range(99) < restart_pct);
        end
    endtask

    initial
    begin
        logic [31:0] h;
        logic [31:0] tol;
        fail_count = 0;
        idle_on = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        h_reg = 4194304;
        asq_reg = 67108864;
        th0_reg = 26353589;
        tol_reg = 0;
        iters_reg = 10;
        theta_st = th0_reg;
        omega_st = 0;
        step_cnt = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values first: steps without and with restart.
        pending_restart = '{1'b0, 1'b0, 1'b1, 1'b0};
        drain();

        // Zero step size, then the largest step with the largest alpha.
        set_regs(32'd0, 32'd67108864, 32'd26353589, 32'd0, 32'd3);
        pending_restart = '{1'b1, 1'b0, 1'b0};
        drain();
        // An iteration limit of zero behaves as one.
        set_regs(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 32'd0);
        pending_restart = '{1'b1, 1'b0, 1'b0, 1'b1};
        drain();
        // A determinant that vanishes: h*h*alpha_sq*cos = -1 with theta = pi.
        set_regs(32'h01000000, 32'h01000000, 32'h03243F6A, 32'h7FFFFFFF, 32'd15);
        pending_restart = '{1'b1, 1'b0, 1'b0};
        drain();
        // Most negative angle, full tolerance; an unmapped register is ignored.
        set_regs(32'h00400000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'd15);
        reg_write(3'd5, 32'hFFFFFFFF);
        reg_write(3'd7, 32'h0);
        pending_restart = '{1'b1, 1'b0, 1'b0, 1'b0};
        drain();
        set_regs(32'h00010000, 32'h00000001, 32'h00000000, 32'h00000010, 32'd15);
        pending_restart = '{1'b1, 1'b0, 1'b0};
        drain();

        // Random phases; small iteration limits keep the run short.
        for (int p = 0; p < 14; p++)
        begin
            case ($urandom_range(3))
                0:       h = $urandom_range(32'h7FFFFFFF);
                1:       h = $urandom_range(32'h00200000);
                default: h = $urandom_range(32'h01000000);
            endcase
            case ($urandom_range(3))
                0:       tol = 0;
                1:       tol = $urandom_range(32'h7FFFFFFF);
                default: tol = $urandom_range(32'h00001000);
            endcase
            set_regs(h, ($urandom_range(3) == 0) ? $urandom_range(32'h7FFFFFFF)
                                                 : $urandom_range(32'h08000000),
                     $urandom(), tol,
                     ($urandom_range(6) == 0) ? $urandom_range(15) : $urandom_range(4));
            // One phase runs with both sides always ready.
            idle_on = (p != 5);
            queue_steps(45, 8);
            // The sender holds off until every outstanding result is back.
            wait (pending_restart.size() == 0 && !step_req.valid);
            wait (expected_steps.size() == 0);
            queue_steps(45, 8);
            drain();
        end

        if (fail_count == 0)
        begin
            $display("PASS pendulum_implicit_euler_newton_top");
        end
        else
        begin
            $display("FAIL pendulum_implicit_euler_newton_top");
        end
        $finish;
    end

    initial
    begin
        #300ms;
        $display("FAIL pendulum_implicit_euler_newton_top");
        $finish;
    end

endmodule

`default_nettype wire

### pendulum_implicit_euler_newton_top.f
src/pien_pkg.sv
src/pien_req_if.sv
src/pien_rsp_if.sv
src/pien_ctrl.sv
src/pien_dp.sv
src/pendulum_implicit_euler_newton_top.sv
tb/sv/tb.sv
